// ----- rtl/voice_sample_mixer_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef VOICE_SAMPLE_MIXER_MACROS_SVH
`define VOICE_SAMPLE_MIXER_MACROS_SVH
// implication checked every clock outside reset
`define VSM_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define VSM_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- rtl/vsm_pkg.sv -----
// shared types and codes for the voice sample mixer
// no dependencies
package vsm_pkg;
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_EFFECT = 3'd1,
    OP_MUSIC  = 3'd2,
    OP_KILL   = 3'd3,
    OP_PAUSE  = 3'd4,
    OP_GAIN   = 3'd5,
    OP_WRITE  = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_ZERO     = 2'd3
  } status_t;

  localparam int unsigned MaxClip = 16384;
  localparam int unsigned FracBits = 12;
endpackage

// ----- rtl/vsm_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module vsm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/voice_sample_mixer.sv -----
// top level of the voice sample mixer: voice tables, sequencer, shared mac
// depends on vsm_pkg and vsm_ram
//
// Sample-playback mixer. A tick walks every effect slot and then every music
// slot through a single sample-memory port and one 16x16 multiplier feeding an
// accumulator. An idle slot is skipped in S_ADDR; an active slot passes through
// S_ADDR and then S_MAC. After the last slot the tick passes through S_DONE
// and offers its result in S_OUT. Control ops (play, kill, pause, gain,
// write) scan the music table one slot per cycle in S_SCAN and then pass
// through S_DONE to S_OUT. The input stall is high from acceptance until
// the result transaction is taken out of the output register. Sum is
// rounded (ties up) and saturated to MIX_BITS.
module voice_sample_mixer #(
  parameter int unsigned EFFECT_VOICES = 8,
  parameter int unsigned MUSIC_VOICES  = 4,
  parameter int unsigned SAMPLE_DEPTH  = 16384,
  parameter int unsigned MIX_BITS      = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_op,
  input  logic [13:0]                in_clip_start,
  input  logic [14:0]                in_clip_length,
  input  logic [15:0]                in_gain,
  input  logic [13:0]                in_sample_addr,
  input  logic signed [15:0]         in_sample_value,
  input  logic signed [MIX_BITS-1:0] in_mix_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [MIX_BITS-1:0] out_mix_out,
  output logic [1:0]                 out_status
);
  import vsm_pkg::*;

  localparam int unsigned NV  = EFFECT_VOICES + MUSIC_VOICES;
  localparam int unsigned VW  = $clog2(NV + 1);
  localparam int unsigned MW  = $clog2(MUSIC_VOICES + 1);
  localparam int unsigned AW  = $clog2(SAMPLE_DEPTH);
  localparam int unsigned ACW = MIX_BITS + 12 + 6 + 2 + 16;

  // one-hot sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ADDR = 6'b000010,
    S_MAC  = 6'b000100,
    S_SCAN = 6'b001000,
    S_DONE = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // voice table, effect slots first then music slots
  logic        vvalid_r [NV];
  logic        vplay_r  [NV];
  logic [13:0] vstart_r [NV];
  logic [14:0] vlen_r   [NV];
  logic [13:0] vpos_r   [NV];
  logic [15:0] vgain_r  [NV];

  // latched transaction
  op_t                       op_r;
  logic [13:0]               start_r;
  logic [14:0]               len_r;
  logic [15:0]               gain_r;
  logic [13:0]               saddr_r;
  logic [15:0]               sval_r;
  logic [VW-1:0]             idx_r;
  logic signed [ACW-1:0]     acc_r;
  logic [MW-1:0]             match_r;
  logic                      found_r;
  logic [MW-1:0]             mfree_r;
  logic                      mfree_ok_r;
  logic signed [MIX_BITS-1:0] mix_r;
  logic [1:0]                stat_r;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [15:0]       ram_q;
  logic [VW-1:0]     cur;

  assign cur = idx_r;

  always_comb begin
    logic [14:0] sum;
    sum = 15'({1'b0, vstart_r[cur[$clog2(NV)-1:0]]} + {1'b0, vpos_r[cur[$clog2(NV)-1:0]]});
    ram_we = (state_r == S_DONE) && (op_r == OP_WRITE);
    if (state_r == S_DONE) begin
      ram_addr = AW'(saddr_r);
    end else begin
      ram_addr = AW'(sum);
    end
  end

  vsm_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (sval_r),
    .rdata (ram_q)
  );

  // shared multiplier: signed sample times unsigned gain
  logic signed [32:0] prod;
  assign prod = $signed(ram_q) * $signed({1'b0, vgain_r[cur[$clog2(NV)-1:0]]});

  // rounding and saturation of the accumulator
  logic signed [ACW-1:0] rnd;
  logic signed [MIX_BITS-1:0] sat;
  always_comb begin
    logic signed [ACW-1:0] hi, lo;
    rnd = (acc_r + ACW'(2048)) >>> FracBits;
    hi  = ACW'((64'sd1 <<< (MIX_BITS - 1)) - 1);
    lo  = -ACW'(64'sd1 <<< (MIX_BITS - 1));
    if (rnd > hi) begin
      sat = MIX_BITS'(hi);
    end else if (rnd < lo) begin
      sat = MIX_BITS'(lo);
    end else begin
      sat = MIX_BITS'(rnd);
    end
  end

  logic [14:0] clen;
  assign clen = (in_clip_length > 15'(MaxClip)) ? 15'(MaxClip) : in_clip_length;

  logic active;
  always_comb begin
    if (cur < VW'(EFFECT_VOICES)) begin
      active = vvalid_r[cur[$clog2(NV)-1:0]];
    end else begin
      active = vvalid_r[cur[$clog2(NV)-1:0]] && vplay_r[cur[$clog2(NV)-1:0]];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_mix_out = mix_r;
  assign out_status  = stat_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) begin
        state_nxt = (op_t'(in_op) == OP_TICK) ? S_ADDR : S_SCAN;
      end
      S_ADDR: begin
        if (cur == VW'(NV)) begin
          state_nxt = S_DONE;
        end else if (active) begin
          state_nxt = S_MAC;
        end
      end
      S_MAC:  state_nxt = S_ADDR;
      S_SCAN: if (cur == VW'(MUSIC_VOICES - 1)) begin
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_OUT;
      S_OUT:  if (!out_stall) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    logic [$clog2(NV)-1:0] c;
    logic [$clog2(NV)-1:0] m;
    logic [14:0] np;
    status_t st;
    c = cur[$clog2(NV)-1:0];
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < NV; i++) begin
        vvalid_r[i] <= 1'b0;
        vplay_r[i]  <= 1'b0;
        vpos_r[i]   <= '0;
        vstart_r[i] <= '0;
        vlen_r[i]   <= '0;
        vgain_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (in_valid) begin
          op_r       <= op_t'(in_op);
          start_r    <= in_clip_start;
          len_r      <= clen;
          gain_r     <= in_gain;
          saddr_r    <= in_sample_addr;
          sval_r     <= in_sample_value;
          acc_r      <= ACW'(in_mix_in) <<< FracBits;
          idx_r      <= '0;
          found_r    <= 1'b0;
          mfree_ok_r <= 1'b0;
          match_r    <= '0;
          mfree_r    <= '0;
        end
        S_ADDR: begin
          if (cur != VW'(NV) && !active) begin
            idx_r <= idx_r + VW'(1);
          end
        end
        S_MAC: begin
          acc_r <= acc_r + ACW'(prod);
          np = 15'(vpos_r[c]) + 15'd1;
          if (np >= vlen_r[c]) begin
            vpos_r[c] <= '0;
            if (cur < VW'(EFFECT_VOICES)) begin
              vvalid_r[c] <= 1'b0;
            end
          end else begin
            vpos_r[c] <= np[13:0];
          end
          idx_r <= idx_r + VW'(1);
        end
        S_SCAN: begin
          m = $clog2(NV)'(EFFECT_VOICES + int'(cur));
          if (!found_r && vvalid_r[m] && vstart_r[m] == start_r) begin
            found_r <= 1'b1;
            match_r <= MW'(cur);
          end
          if (!mfree_ok_r && !vvalid_r[m]) begin
            mfree_ok_r <= 1'b1;
            mfree_r    <= MW'(cur);
          end
          idx_r <= idx_r + VW'(1);
        end
        S_DONE: begin
          st = ST_OK;
          mix_r <= (op_r == OP_TICK) ? sat : '0;
          m = $clog2(NV)'(EFFECT_VOICES + int'(match_r));
          case (op_r)
            OP_TICK: ;
            OP_EFFECT: begin
              if (len_r == '0) begin
                st = ST_ZERO;
              end else begin
                logic hit;
                hit = 1'b0;
                for (int i = 0; i < EFFECT_VOICES; i++) begin
                  if (!hit && !vvalid_r[i]) begin
                    hit = 1'b1;
                    vvalid_r[i] <= 1'b1;
                    vstart_r[i] <= start_r;
                    vlen_r[i]   <= len_r;
                    vpos_r[i]   <= '0;
                    vgain_r[i]  <= gain_r;
                  end
                end
                if (!hit) begin
                  st = ST_FULL;
                end
              end
            end
            OP_MUSIC: begin
              if (len_r == '0) begin
                st = ST_ZERO;
              end else if (found_r) begin
                vplay_r[m] <= 1'b1;
              end else if (mfree_ok_r) begin
                m = $clog2(NV)'(EFFECT_VOICES + int'(mfree_r));
                vvalid_r[m] <= 1'b1;
                vplay_r[m]  <= 1'b1;
                vstart_r[m] <= start_r;
                vlen_r[m]   <= len_r;
                vpos_r[m]   <= '0;
                vgain_r[m]  <= gain_r;
              end else begin
                st = ST_FULL;
              end
            end
            OP_KILL: begin
              if (!found_r) begin
                st = ST_NOTFOUND;
              end else begin
                vvalid_r[m] <= 1'b0;
                vplay_r[m]  <= 1'b0;
                vpos_r[m]   <= '0;
              end
            end
            OP_PAUSE: begin
              if (!found_r) begin
                st = ST_NOTFOUND;
              end else begin
                vplay_r[m] <= 1'b0;
              end
            end
            OP_GAIN: begin
              if (!found_r) begin
                st = ST_NOTFOUND;
              end else begin
                vgain_r[m] <= gain_r;
              end
            end
            default: ;
          endcase
          stat_r <= st;
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- rtl/voice_sample_mixer_checker.sv -----
// port-level checker for the voice sample mixer, bound to the top level
// depends on vsm_pkg and voice_sample_mixer_macros.svh
`include "voice_sample_mixer_macros.svh"
module voice_sample_mixer_checker #(
  parameter int unsigned MIX_BITS = 24
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [2:0]          in_op,
  input logic                out_valid,
  input logic                out_stall,
  input logic [MIX_BITS-1:0] out_mix_out,
  input logic [1:0]          out_status
);
  import vsm_pkg::*;

  // accepted transaction blocks further input at once
  `VSM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // no result while the input side is open
  `VSM_ASSERT_IMP(a_out_only_busy, clk, rst_n, out_valid, in_stall)
  // an offered transaction carries a known op code
  `VSM_ASSERT_IMP(a_op_known, clk, rst_n, in_valid, !$isunknown(in_op))
  // a stalled result holds its value
  `VSM_ASSERT_NXT(a_waiting_result_holds, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_mix_out) && $stable(out_status))
endmodule

bind voice_sample_mixer voice_sample_mixer_checker #(.MIX_BITS(MIX_BITS)) u_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
  .out_valid(out_valid), .out_stall(out_stall), .out_mix_out(out_mix_out),
  .out_status(out_status)
);

// ----- tb/sv/voice_sample_mixer_tb.sv -----
// self-checking testbench for voice_sample_mixer: directed then random transactions
// depends on vsm_pkg and the voice_sample_mixer rtl
module voice_sample_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vsm_pkg::*;

  localparam int NumFx = 8;
  localparam int NumMus = 4;
  localparam int Depth = 16384;
  localparam int Region = 128;
  localparam int WatchLimit = 4000;

  typedef struct packed {
    op_t                op;
    logic [13:0]        clip_start;
    logic [14:0]        clip_length;
    logic [15:0]        gain;
    logic [13:0]        sample_addr;
    logic signed [15:0] sample_value;
    logic signed [23:0] mix_in;
  } cmd_t;

  typedef struct packed {
    logic signed [23:0] mix;
    status_t            status;
  } mix_res_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [2:0] in_op;
  logic [13:0] in_clip_start, in_sample_addr;
  logic [14:0] in_clip_length;
  logic [15:0] in_gain;
  logic signed [15:0] in_sample_value;
  logic signed [23:0] in_mix_in, out_mix_out;
  logic [1:0] out_status;

  voice_sample_mixer DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_clip_start, .in_clip_length,
    .in_gain, .in_sample_addr, .in_sample_value, .in_mix_in, .out_valid,
    .out_stall, .out_mix_out, .out_status
  );

  // predictor state: own copy of sample memory and voice tables
  logic signed [15:0] mem [Depth];
  bit                 fx_on [NumFx];
  logic [13:0]        fx_base [NumFx];
  logic [14:0]        fx_len [NumFx];
  logic [14:0]        fx_pos [NumFx];
  logic [15:0]        fx_gain [NumFx];
  bit                 mus_on [NumMus];
  bit                 mus_run [NumMus];
  logic [13:0]        mus_base [NumMus];
  logic [14:0]        mus_len [NumMus];
  logic [14:0]        mus_pos [NumMus];
  logic [15:0]        mus_gain [NumMus];

  cmd_t     pending_cmds[$];
  mix_res_t expected_mix[$];
  int       errors = 0;
  int       n_sent = 0, n_got = 0, n_ticks = 0;
  int       idle_cycles = 0;
  bit       hold_rx = 0;   // long receiver hold-off request
  bit       drain_rx = 0;  // sender waits for all expected results before each item while this is set
  logic [13:0] loaded_base [$]; // clip starts whose short clips stay in written memory

  function automatic logic signed [15:0] rd(logic [13:0] base, logic [14:0] pos);
    logic [13:0] a;
    a = 14'(base + pos);
    return mem[a];
  endfunction

  function automatic int find_mus(logic [13:0] s);
    for (int i = 0; i < NumMus; i++)
      if (mus_on[i] && mus_base[i] == s) return i;
    return -1;
  endfunction

  // compute the expected mix result and update the voice tables and sample memory
  function automatic mix_res_t mix_step(cmd_t c);
    mix_res_t r;
    longint acc, q;
    logic [14:0] len;
    int k;
    r.mix = '0;
    r.status = ST_OK;
    len = (c.clip_length > MaxClip) ? 15'(MaxClip) : c.clip_length;
    k = -1;
    case (c.op)
      OP_TICK: begin
        acc = longint'(c.mix_in) * 4096;
        for (int i = 0; i < NumFx; i++) if (fx_on[i]) begin
          acc += longint'(rd(fx_base[i], fx_pos[i])) * longint'(fx_gain[i]);
          fx_pos[i]++;
          if (fx_pos[i] >= fx_len[i]) begin
            fx_on[i] = 0;
            fx_pos[i] = 0;
          end
        end
        for (int i = 0; i < NumMus; i++) if (mus_on[i] && mus_run[i]) begin
          acc += longint'(rd(mus_base[i], mus_pos[i])) * longint'(mus_gain[i]);
          mus_pos[i]++;
          if (mus_pos[i] >= mus_len[i]) mus_pos[i] = 0;
        end
        q = (acc + 2048) >>> 12;
        if (q > 8388607) q = 8388607;
        if (q < -8388608) q = -8388608;
        r.mix = 24'(q);
      end
      OP_EFFECT: begin
        if (len == 0) r.status = ST_ZERO;
        else begin
          for (int i = 0; i < NumFx; i++) if (!fx_on[i] && k < 0) k = i;
          if (k < 0) r.status = ST_FULL;
          else begin
            fx_on[k] = 1; fx_base[k] = c.clip_start; fx_len[k] = len;
            fx_pos[k] = 0; fx_gain[k] = c.gain;
          end
        end
      end
      OP_MUSIC: begin
        if (len == 0) r.status = ST_ZERO;
        else begin
          k = find_mus(c.clip_start);
          if (k >= 0) mus_run[k] = 1;
          else begin
            for (int i = 0; i < NumMus; i++) if (!mus_on[i] && k < 0) k = i;
            if (k < 0) r.status = ST_FULL;
            else begin
              mus_on[k] = 1; mus_run[k] = 1; mus_base[k] = c.clip_start;
              mus_len[k] = len; mus_pos[k] = 0; mus_gain[k] = c.gain;
            end
          end
        end
      end
      OP_KILL, OP_PAUSE, OP_GAIN: begin
        k = find_mus(c.clip_start);
        if (k < 0) r.status = ST_NOTFOUND;
        else if (c.op == OP_KILL) begin
          mus_on[k] = 0; mus_run[k] = 0; mus_pos[k] = 0;
        end else if (c.op == OP_PAUSE) mus_run[k] = 0;
        else mus_gain[k] = c.gain;
      end
      OP_WRITE: begin
        mem[c.sample_addr] = c.sample_value;
      end
      default: ;
    endcase
    return r;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: one transaction at a time, random gap drawn per item
  int gap_left = 0;
  initial begin
    rst_n = 0; in_valid = 0; out_stall = 0;
    in_op = '0; in_clip_start = '0; in_clip_length = '0; in_gain = '0;
    in_sample_addr = '0; in_sample_value = '0; in_mix_in = '0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_mix.push_back(mix_step(cmd_t'({op_t'(in_op), in_clip_start,
          in_clip_length, in_gain, in_sample_addr, in_sample_value, in_mix_in})));
        if (in_op == OP_TICK) n_ticks++;
        n_sent++;
        gap_left = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap_left = 0;
      end
      if (!(in_valid && in_stall)) begin
        // drain pause holds the sender until every expected result has come
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 0;
        end else if (pending_cmds.size() > 0 && !(drain_rx && expected_mix.size() > 0)) begin
          cmd_t c;
          c = pending_cmds.pop_front();
          in_valid <= 1;
          in_op <= c.op; in_clip_start <= c.clip_start; in_clip_length <= c.clip_length;
          in_gain <= c.gain; in_sample_addr <= c.sample_addr;
          in_sample_value <= c.sample_value; in_mix_in <= c.mix_in;
        end else in_valid <= 0;
      end
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_got++;
        if (expected_mix.size() == 0) begin
          $error("unexpected result transaction mix_out=%0d status=%0d",
                 out_mix_out, out_status);
          errors++;
        end else begin
          mix_res_t e;
          e = expected_mix.pop_front();
          if (out_mix_out !== e.mix) begin
            $error("mix_out expected %0d actual %0d", e.mix, out_mix_out);
            errors++;
          end
          if (out_status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_status);
            errors++;
          end
        end
        stall_left = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) stall_left = 0;
      end
      // stall follows the hold-off request, else the random stall count drawn per result
      if (hold_rx) out_stall <= 1;
      else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1;
      end else out_stall <= 0;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_rx
        || !rst_n) idle_cycles <= 0;
    else if (pending_cmds.size() > 0 || expected_mix.size() > 0 || in_valid) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("timeout waiting for a transaction");
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic cmd_t blank(op_t op);
    cmd_t c;
    c = '0;
    c.op = op;
    return c;
  endfunction

  task automatic add_write(int a, int v);
    cmd_t c;
    c = blank(OP_WRITE);
    c.sample_addr = 14'(a);
    c.sample_value = 16'(v);
    pending_cmds.push_back(c);
  endtask

  task automatic add_voice(op_t op, logic [13:0] s, int len, int g);
    cmd_t c;
    c = blank(op);
    c.clip_start = s;
    c.clip_length = 15'(len);
    c.gain = 16'(g);
    pending_cmds.push_back(c);
  endtask

  task automatic add_tick(int m);
    cmd_t c;
    c = blank(OP_TICK);
    c.mix_in = 24'(m);
    // random bits elsewhere must be ignored by the block
    c.sample_addr = 14'($urandom);
    pending_cmds.push_back(c);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || expected_mix.size() > 0 || in_valid)
      @(posedge clk);
  endtask

  // pick a loaded clip start so a voice never reads unwritten memory
  function automatic logic [13:0] any_clip();
    return loaded_base[$urandom_range(0, loaded_base.size() - 1)];
  endfunction

  // stimulus
  initial begin
    logic [13:0] b;
    int r;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // fill a window at each end of memory; every voice read stays inside it
    // (short clips starting near either end, reads wrap across the top)
    drain_rx = 0;
    // directed: extremes of the sample value and memory wrap
    add_write(0, 32767);
    add_write(Depth - 1, -32768);
    add_tick(8388607);
    add_tick(-8388608);
    for (int a = 1; a < Region; a++) add_write(a, $urandom);
    for (int a = Depth - Region; a < Depth - 1; a++) add_write(a, $urandom);
    for (int i = 0; i < 32; i++) loaded_base.push_back(14'($urandom_range(0, 63)));
    for (int i = 0; i < 32; i++)
      loaded_base.push_back(14'(Depth - 64 + $urandom_range(0, 63)));
    loaded_base.push_back(14'(Depth - 1));
    loaded_base.push_back(14'd0);
    wait_drained();

    // directed voice cases: zero length, full tables, not found
    add_voice(OP_EFFECT, 14'd0, 0, 4096);
    add_voice(OP_MUSIC, 14'd5, 0, 4096);
    add_voice(OP_KILL, 14'd77, 0, 0);
    add_voice(OP_PAUSE, 14'd77, 0, 0);
    add_voice(OP_GAIN, 14'd77, 0, 0);
    for (int i = 0; i < 9; i++) add_voice(OP_EFFECT, 14'(i * 3), 1 + i, 65535);
    add_tick(8388607);
    add_tick(-8388608);
    for (int i = 0; i < 5; i++) add_voice(OP_MUSIC, 14'(100 + i), 3, 4096 * i);
    add_voice(OP_MUSIC, 14'd100, 3, 1);
    add_voice(OP_PAUSE, 14'd101, 0, 0);
    add_voice(OP_GAIN, 14'd102, 0, 65535);
    add_tick(0);
    add_voice(OP_KILL, 14'd103, 0, 0);
    add_voice(OP_MUSIC, 14'd101, 5, 0);
    pending_cmds.push_back(blank(OP_NONE));
    add_tick(-1);
    // long clip clamps to the full depth and wraps the address; killed soon
    add_voice(OP_MUSIC, 14'(Depth - 1), 32767, 65535);
    add_tick(1000);
    add_tick(-1000);
    add_tick(0);
    add_voice(OP_KILL, 14'(Depth - 1), 0, 0);
    for (int i = 0; i < 3; i++) add_voice(OP_KILL, 14'(100 + i), 0, 0);
    wait_drained();

    // random phases
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        // receiver holds off while the sender keeps offering
        hold_rx = 1;
        for (int i = 0; i < 10; i++) add_tick($urandom);
        repeat (200) @(posedge clk);
        hold_rx = 0;
        wait_drained();
      end
      drain_rx = (phase == 4);
      for (int i = 0; i < 250; i++) begin
        cmd_t c;
        r = $urandom_range(0, 99);
        b = any_clip();
        c.op = OP_TICK;
        c.clip_start = b;
        c.clip_length = 15'($urandom_range(0, 40));
        c.gain = 16'($urandom);
        c.sample_addr = 14'($urandom);
        c.sample_value = 16'($urandom);
        c.mix_in = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                 : 24'($signed(16'($urandom)));
        if (r < 45) c.op = OP_TICK;
        else if (r < 60) c.op = OP_EFFECT;
        else if (r < 70) c.op = OP_MUSIC;
        else if (r < 76) c.op = OP_KILL;
        else if (r < 82) c.op = OP_PAUSE;
        else if (r < 88) c.op = OP_GAIN;
        else if (r < 98) c.op = OP_WRITE;
        else c.op = OP_NONE;
        // lookups of arbitrary clip starts mostly miss
        if ((c.op == OP_KILL || c.op == OP_PAUSE || c.op == OP_GAIN)
            && $urandom_range(0, 9) == 0) c.clip_start = 14'($urandom);
        pending_cmds.push_back(c);
      end
      wait_drained();
      drain_rx = 0;
    end

    repeat (40) @(posedge clk);
    $display("covered %0d transactions (%0d ticks), %0d results checked",
             n_sent, n_ticks, n_got);
    if (errors == 0 && expected_mix.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ----- voice_sample_mixer.f -----
+incdir+rtl
rtl/vsm_pkg.sv
rtl/vsm_ram.sv
rtl/voice_sample_mixer.sv
rtl/voice_sample_mixer_checker.sv
tb/sv/voice_sample_mixer_tb.sv
